### rtl/address_port_rule_classifier_unit_assert.svh
// assertion macros used by the rule classifier unit
`ifndef ADDRESS_PORT_RULE_CLASSIFIER_UNIT_ASSERT_SVH
`define ADDRESS_PORT_RULE_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication
`define APRC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APRC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/aprc_pkg.sv
package aprc_pkg;

   localparam logic [1:0] CMD_CLEAR    = 2'd0;
   localparam logic [1:0] CMD_APPEND   = 2'd1;
   localparam logic [1:0] CMD_CLASSIFY = 2'd2;

   localparam logic [1:0] VERDICT_ACCEPTED      = 2'd0;
   localparam logic [1:0] VERDICT_PROB_ACCEPTED = 2'd1;
   localparam logic [1:0] VERDICT_REJECTED      = 2'd2;
   localparam logic [1:0] VERDICT_PROB_REJECTED = 2'd3;

   localparam logic [15:0] ALL_PORTS_HIGH = 16'd65535;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] mask;
      logic [15:0] port_low;
      logic [15:0] port_high;
      logic        rejects;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   typedef struct packed {
      logic definite;
      logic uncertain;
   } hit_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

endpackage

### rtl/aprc_ram.sv
module aprc_ram #(
   parameter int WIDTH = 97,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/aprc_match.sv
module aprc_match (
   input  aprc_pkg::rule_type rule,
   input  logic [31:0]        query_address,
   input  logic [15:0]        query_port,
   output aprc_pkg::hit_type  hit
);
   import aprc_pkg::*;

   logic in_range;
   logic port_unknown;
   logic whole_range;
   logic port_fits;
   logic addr_match;

   always_comb begin
      in_range     = (query_port >= rule.port_low) && (query_port <= rule.port_high);
      port_unknown = (query_port == 16'd0);
      whole_range  = port_unknown && (rule.port_low <= 16'd1)
                     && (rule.port_high == ALL_PORTS_HIGH);
      port_fits    = in_range || whole_range;
      addr_match   = ((query_address & rule.mask) == (rule.address & rule.mask));
      if (query_address == 32'd0) begin
         // unknown address: only an any-address rule can match for sure
         hit.definite  = port_fits && (rule.mask == 32'd0);
         hit.uncertain = port_fits ? (rule.mask != 32'd0) : port_unknown;
      end else begin
         hit.definite  = addr_match && in_range;
         hit.uncertain = addr_match && !in_range && port_unknown;
      end
   end

endmodule

### rtl/address_port_rule_classifier_unit.sv
// first-match address and port rule classifier
// a command word is taken when start is high and busy is low; req_command
// selects clear (0), append (1) or classify (2); code 3 does nothing
// every accepted word gives exactly one result word on the rsp_ ports,
// shown for one cycle with rsp_strobe high; the receiver cannot stall
// clear, append and unused codes: result in the cycle after acceptance, busy
// stays low, so these commands run at one per cycle
// classify: rules are read from the rule ram one per cycle in table order;
// the walk stops at the first definite match or the last stored rule, so a
// query visits at most RULE_SLOTS rules; an empty table answers without a
// walk, in the cycle after acceptance
// busy is high while the walk runs; the next command may be taken in the
// cycle the result is shown
// an append to a full table is dropped and reported with rsp_table_full
// reset empties the table (rule count to zero); the ram is not cleared,
// entries past the count are never read
module address_port_rule_classifier_unit #(
   parameter int RULE_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_rule_address,
   input  logic [31:0] req_rule_mask,
   input  logic [15:0] req_rule_port_low,
   input  logic [15:0] req_rule_port_high,
   input  logic        req_rule_rejects,
   input  logic [31:0] req_query_address,
   input  logic [15:0] req_query_port,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict,
   output logic        rsp_permitted,
   output logic        rsp_table_full
);
   import aprc_pkg::*;

   localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RULE_SLOTS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             might_reject_ff, might_reject_in;
   logic             might_accept_ff, might_accept_in;
   logic [31:0]      qaddr_ff, qaddr_in;
   logic [15:0]      qport_ff, qport_in;
   logic             strobe_ff, strobe_in;
   logic [1:0]       verdict_ff, verdict_in;
   logic             permitted_ff, permitted_in;
   logic             full_ff, full_in;

   logic             accept;
   logic             table_is_full;
   logic [CNT_W-1:0] scan_next;
   logic             scan_last;
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   rule_type         wr_rule;
   rule_type         rd_rule;
   logic [RULE_W-1:0] rd_word;
   hit_type          hit;

   assign accept        = start && (state_ff == ST_IDLE);
   assign busy          = (state_ff != ST_IDLE);
   assign table_is_full = (count_ff == CNT_W'(RULE_SLOTS));
   assign scan_next     = CNT_W'(scan_idx_ff) + CNT_W'(1);
   assign scan_last     = (scan_next == count_ff);
   assign rd_rule       = rule_type'(rd_word);

   always_comb begin
      wr_rule.address   = req_rule_address;
      wr_rule.mask      = req_rule_mask;
      wr_rule.port_low  = req_rule_port_low;
      wr_rule.port_high = req_rule_port_high;
      wr_rule.rejects   = req_rule_rejects;
   end

   aprc_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULE_SLOTS),
      .AW    (IDX_W)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   aprc_match u_match (
      .rule          (rd_rule),
      .query_address (qaddr_ff),
      .query_port    (qport_ff),
      .hit           (hit)
   );

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      scan_idx_in     = scan_idx_ff;
      might_reject_in = might_reject_ff;
      might_accept_in = might_accept_ff;
      qaddr_in        = qaddr_ff;
      qport_in        = qport_ff;
      strobe_in       = 1'b0;
      verdict_in      = verdict_ff;
      permitted_in    = permitted_ff;
      full_in         = full_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      rd_addr         = scan_next[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               verdict_in   = VERDICT_ACCEPTED;
               permitted_in = 1'b0;
               full_in      = 1'b0;
               case (req_command)
                  CMD_CLEAR: begin
                     count_in  = '0;
                     strobe_in = 1'b1;
                  end
                  CMD_APPEND: begin
                     strobe_in = 1'b1;
                     if (table_is_full) begin
                        full_in = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_CLASSIFY: begin
                     qaddr_in        = req_query_address;
                     qport_in        = req_query_port;
                     might_reject_in = 1'b0;
                     might_accept_in = 1'b0;
                     if (count_ff == '0) begin
                        permitted_in = 1'b1;
                        strobe_in    = 1'b1;
                     end else begin
                        // fetch the first rule, it lands as the walk starts
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        scan_idx_in = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit.uncertain) begin
               if (rd_rule.rejects) begin
                  might_reject_in = 1'b1;
               end else begin
                  might_accept_in = 1'b1;
               end
            end
            if (hit.definite) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
               if (rd_rule.rejects) begin
                  verdict_in   = might_accept_ff ? VERDICT_PROB_REJECTED : VERDICT_REJECTED;
                  permitted_in = 1'b0;
               end else begin
                  verdict_in   = might_reject_ff ? VERDICT_PROB_ACCEPTED : VERDICT_ACCEPTED;
                  permitted_in = 1'b1;
               end
            end else if (scan_last) begin
               // no definite match: default accept, weakened by any maybe-reject
               strobe_in    = 1'b1;
               state_in     = ST_IDLE;
               permitted_in = 1'b1;
               verdict_in   = (might_reject_ff || (hit.uncertain && rd_rule.rejects))
                              ? VERDICT_PROB_ACCEPTED : VERDICT_ACCEPTED;
            end else begin
               rd_en       = 1'b1;
               scan_idx_in = scan_next[IDX_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      might_reject_ff <= might_reject_in;
      might_accept_ff <= might_accept_in;
      qaddr_ff        <= qaddr_in;
      qport_ff        <= qport_in;
      verdict_ff      <= verdict_in;
      permitted_ff    <= permitted_in;
      full_ff         <= full_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_verdict    = verdict_ff;
   assign rsp_permitted  = permitted_ff;
   assign rsp_table_full = full_ff;

`include "address_port_rule_classifier_unit_assert.svh"

   `APRC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(RULE_SLOTS), "rule count past table size")
   `APRC_ASSERT_NOW(a_no_strobe_in_scan, clock, reset, state_ff == ST_SCAN, !strobe_ff, "result word during rule walk")
   `APRC_ASSERT_NEXT(a_short_cmd_result, clock, reset, accept && (req_command != CMD_CLASSIFY), strobe_ff && (state_ff == ST_IDLE), "short command gave no result")
   `APRC_ASSERT_NOW(a_permit_matches_verdict, clock, reset, strobe_ff && permitted_ff, !verdict_ff[1], "permitted with a reject verdict")
   `APRC_ASSERT_NOW(a_full_only_append, clock, reset, strobe_ff && full_ff, (verdict_ff == VERDICT_ACCEPTED) && !permitted_ff, "table full flag with a verdict")

endmodule
